@@ src/sita_pkg.sv @@
package sita_pkg;

  localparam int CAPACITY = 256;
  localparam int GROUP_SIZE = 3;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 10;
  localparam int STATUS_W = 2;

  // sum of three values, and divide by three as multiply by reciprocal
  localparam int SUM_W = VAL_W + 2;
  localparam int DIV_SHIFT = SUM_W + 1;
  localparam int DIV_MUL = (2 ** DIV_SHIFT + 2) / 3;
  localparam int PROD_W = SUM_W + DIV_SHIFT;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] record_key;
    logic [VAL_W-1:0] record_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    group_key;
    logic [VAL_W-1:0]    group_average;
  } out_t;

  // request to the record store: one write and one read per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wkey;
    logic [VAL_W-1:0]  wval;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_TAKE_SHORT,
    S_TAKE1,
    S_TAKE2,
    S_TAKE3,
    S_TAKE_DIV
  } state_t;

  // physical slot of a logical position in the circular store
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (ADDR_W+1)'(CAPACITY)) begin
      s = s - (ADDR_W+1)'(CAPACITY);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

@@ src/sita_store.sv @@
module sita_store (
  input  logic                         clk,
  input  sita_pkg::mem_req_t           mem_req,
  output logic [sita_pkg::KEY_W-1:0]   rkey,
  output logic [sita_pkg::VAL_W-1:0]   rval
);

  logic [sita_pkg::KEY_W-1:0] key_mem [sita_pkg::CAPACITY];
  logic [sita_pkg::VAL_W-1:0] val_mem [sita_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      key_mem[mem_req.waddr] <= mem_req.wkey;
      val_mem[mem_req.waddr] <= mem_req.wval;
    end
    if (mem_req.re) begin
      rkey <= key_mem[mem_req.raddr];
      rval <= val_mem[mem_req.raddr];
    end
  end

endmodule

@@ src/sorted_insert_triple_average_top.sv @@
// Sorted record store with grouped take.
// Request channel: request is taken at a rising edge where start is high and
// busy is low. kind 0 inserts (record_key, record_value) in key order; kind 1
// takes the three lowest records (all, if fewer than three) and returns the first
// key and, for a full group of three, the truncated average of the three values.
// Result channel: every request gives one result, shown on result for one
// cycle with result_valid high; the receiver cannot stall it.
// Records live in a circular store (one synchronous RAM pair, one read and one
// write a cycle). Insert walks back from the tail, moving one record a cycle.
// Work from accept to result_valid:
//   insert into empty or full store, take from empty store: no store read
//   insert: read the tail, walk back moving records, then write the new record
//   short take (one or two records): read the head record, then the result
//   take of a full group: three reads, then the divide by three
// One request is worked on at a time; busy is high until the result shows,
// and a new request may be taken in the cycle its result is on the ports.
// Reset empties the store at once (fill count and head cleared); no sweep.
module sorted_insert_triple_average_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sita_pkg::in_t   request,
  output logic            result_valid,
  output sita_pkg::out_t  result
);

  sita_pkg::state_t   state, state_next;
  sita_pkg::mem_req_t mem_req;

  logic [sita_pkg::ADDR_W-1:0]  head, head_next;
  logic [sita_pkg::COUNT_W-1:0] fill, fill_next;
  logic [sita_pkg::ADDR_W-1:0]  j, j_next;
  logic [sita_pkg::KEY_W-1:0]   ins_key, ins_key_next;
  logic [sita_pkg::VAL_W-1:0]   ins_val, ins_val_next;
  logic [sita_pkg::KEY_W-1:0]   grp_key, grp_key_next;
  logic [sita_pkg::SUM_W-1:0]   acc, acc_next;
  logic [sita_pkg::KEY_W-1:0]   rkey;
  logic [sita_pkg::VAL_W-1:0]   rval;
  sita_pkg::out_t               result_next;
  logic                         result_valid_next;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         short_group;
  logic [sita_pkg::ADDR_W-1:0]  fill_last;
  logic                         shift;
  logic [sita_pkg::PROD_W-1:0]  prod;

  sita_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rkey    (rkey),
    .rval    (rval)
  );

  assign busy        = (state != sita_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign full        = (fill >= sita_pkg::COUNT_W'(sita_pkg::CAPACITY));
  assign empty       = (fill == '0);
  assign short_group = (fill < sita_pkg::COUNT_W'(sita_pkg::GROUP_SIZE));
  assign fill_last   = fill[sita_pkg::ADDR_W-1:0] - sita_pkg::ADDR_W'(1);
  // a key equal to the tail goes after it; elsewhere it goes before equal keys
  assign shift       = (j == fill_last) ? (rkey > ins_key) : (rkey >= ins_key);
  assign prod        = sita_pkg::PROD_W'(acc) * sita_pkg::PROD_W'(sita_pkg::DIV_MUL);

  always_comb begin
    state_next = state;
    case (state)
      sita_pkg::S_IDLE: begin
        if (accept) begin
          if (request.kind == sita_pkg::KIND_INSERT) begin
            if (!full && !empty) state_next = sita_pkg::S_INS_WALK;
          end else if (!empty) begin
            state_next = short_group ? sita_pkg::S_TAKE_SHORT : sita_pkg::S_TAKE1;
          end
        end
      end
      sita_pkg::S_INS_WALK: begin
        if (!shift) state_next = sita_pkg::S_IDLE;
        else if (j == '0) state_next = sita_pkg::S_INS_PUT;
      end
      sita_pkg::S_INS_PUT:    state_next = sita_pkg::S_IDLE;
      sita_pkg::S_TAKE_SHORT: state_next = sita_pkg::S_IDLE;
      sita_pkg::S_TAKE1:      state_next = sita_pkg::S_TAKE2;
      sita_pkg::S_TAKE2:      state_next = sita_pkg::S_TAKE3;
      sita_pkg::S_TAKE3:      state_next = sita_pkg::S_TAKE_DIV;
      sita_pkg::S_TAKE_DIV:   state_next = sita_pkg::S_IDLE;
      default:                state_next = sita_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_req           = '0;
    head_next         = head;
    fill_next         = fill;
    j_next            = j;
    ins_key_next      = ins_key;
    ins_val_next      = ins_val;
    grp_key_next      = grp_key;
    acc_next          = acc;
    result_valid_next = 1'b0;
    result_next       = '0;
    case (state)
      sita_pkg::S_IDLE: begin
        if (accept) begin
          ins_key_next = request.record_key;
          ins_val_next = request.record_value;
          if (request.kind == sita_pkg::KIND_INSERT) begin
            if (full) begin
              result_valid_next  = 1'b1;
              result_next.status = sita_pkg::ST_FULL;
            end else if (empty) begin
              mem_req.we         = 1'b1;
              mem_req.waddr      = head;
              mem_req.wkey       = request.record_key;
              mem_req.wval       = request.record_value;
              fill_next          = fill + sita_pkg::COUNT_W'(1);
              result_valid_next  = 1'b1;
              result_next.status = sita_pkg::ST_OK;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = sita_pkg::phys(head, fill_last);
              j_next        = fill_last;
            end
          end else begin
            if (empty) begin
              result_valid_next  = 1'b1;
              result_next.status = sita_pkg::ST_EMPTY;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = head;
            end
          end
        end
      end
      sita_pkg::S_INS_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sita_pkg::phys(head, j + sita_pkg::ADDR_W'(1));
        if (shift) begin
          mem_req.wkey = rkey;
          mem_req.wval = rval;
          if (j != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = sita_pkg::phys(head, j - sita_pkg::ADDR_W'(1));
            j_next        = j - sita_pkg::ADDR_W'(1);
          end
        end else begin
          mem_req.wkey       = ins_key;
          mem_req.wval       = ins_val;
          fill_next          = fill + sita_pkg::COUNT_W'(1);
          result_valid_next  = 1'b1;
          result_next.status = sita_pkg::ST_OK;
        end
      end
      sita_pkg::S_INS_PUT: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = head;
        mem_req.wkey       = ins_key;
        mem_req.wval       = ins_val;
        fill_next          = fill + sita_pkg::COUNT_W'(1);
        result_valid_next  = 1'b1;
        result_next.status = sita_pkg::ST_OK;
      end
      sita_pkg::S_TAKE_SHORT: begin
        fill_next             = '0;
        result_valid_next     = 1'b1;
        result_next.status    = sita_pkg::ST_SHORT;
        result_next.group_key = rkey;
      end
      sita_pkg::S_TAKE1: begin
        grp_key_next  = rkey;
        acc_next      = sita_pkg::SUM_W'(rval);
        mem_req.re    = 1'b1;
        mem_req.raddr = sita_pkg::phys(head, sita_pkg::ADDR_W'(1));
      end
      sita_pkg::S_TAKE2: begin
        acc_next      = acc + sita_pkg::SUM_W'(rval);
        mem_req.re    = 1'b1;
        mem_req.raddr = sita_pkg::phys(head, sita_pkg::ADDR_W'(2));
      end
      sita_pkg::S_TAKE3: begin
        acc_next = acc + sita_pkg::SUM_W'(rval);
      end
      sita_pkg::S_TAKE_DIV: begin
        head_next                 = sita_pkg::phys(head, sita_pkg::ADDR_W'(sita_pkg::GROUP_SIZE));
        fill_next                 = fill - sita_pkg::COUNT_W'(sita_pkg::GROUP_SIZE);
        result_valid_next         = 1'b1;
        result_next.status        = sita_pkg::ST_OK;
        result_next.group_key     = grp_key;
        result_next.group_average = prod[sita_pkg::DIV_SHIFT +: sita_pkg::VAL_W];
      end
      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sita_pkg::S_IDLE;
      head         <= '0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      fill         <= fill_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    j       <= j_next;
    ins_key <= ins_key_next;
    ins_val <= ins_val_next;
    grp_key <= grp_key_next;
    acc     <= acc_next;
    result  <= result_next;
  end

endmodule

@@ src/sita_checker.sv @@
module sita_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input sita_pkg::in_t  request,
  input logic           result_valid,
  input sita_pkg::out_t result
);

  // every accepted request either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_valid))
    else $error("accepted request neither busy nor answered");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid)
    else $error("busy dropped without a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || $past(start && !busy)))
    else $error("result without a request");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == sita_pkg::ST_FULL
                      || result.status == sita_pkg::ST_EMPTY))
      |-> (result.group_key == '0 && result.group_average == '0))
    else $error("error result carries nonzero fields");

endmodule

bind sorted_insert_triple_average_top sita_checker u_sita_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  sita_pkg::in_t request = '0;
  logic result_valid;
  sita_pkg::out_t result;

  sorted_insert_triple_average_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  always #2 clk = ~clk;

  sita_pkg::in_t pending_q[$];
  sita_pkg::out_t expected_results[$];
  logic [sita_pkg::KEY_W-1:0] sorted_keys[$];
  logic [sita_pkg::VAL_W-1:0] sorted_vals[$];
  int idle_pct = 0;
  int error_count = 0;
  int gen_fill = 0;
  int quiet_cycles = 0;

  // mirror of the store: updates it for one accepted request and queues the result
  task automatic predict_result(input sita_pkg::in_t r);
    sita_pkg::out_t o;
    int pos;
    int sum;
    o = '0;
    if (r.kind == sita_pkg::KIND_INSERT) begin
      if (sorted_keys.size() >= sita_pkg::CAPACITY) begin
        o.status = sita_pkg::ST_FULL;
      end else begin
        pos = sorted_keys.size();
        if (pos != 0 && sorted_keys[pos-1] > r.record_key) begin
          for (int i = 0; i < sorted_keys.size(); i++) begin
            if (sorted_keys[i] >= r.record_key) begin
              pos = i;
              break;
            end
          end
        end
        sorted_keys.insert(pos, r.record_key);
        sorted_vals.insert(pos, r.record_value);
        o.status = sita_pkg::ST_OK;
      end
    end else if (sorted_keys.size() == 0) begin
      o.status = sita_pkg::ST_EMPTY;
    end else if (sorted_keys.size() < sita_pkg::GROUP_SIZE) begin
      o.status = sita_pkg::ST_SHORT;
      o.group_key = sorted_keys[0];
      sorted_keys.delete();
      sorted_vals.delete();
    end else begin
      o.status = sita_pkg::ST_OK;
      o.group_key = sorted_keys[0];
      sum = 0;
      for (int i = 0; i < sita_pkg::GROUP_SIZE; i++) begin
        sum += sorted_vals.pop_front();
        void'(sorted_keys.pop_front());
      end
      o.group_average = sita_pkg::VAL_W'(sum / sita_pkg::GROUP_SIZE);
    end
    expected_results.push_back(o);
  endtask

  // driver: holds a request until accepted, idles at random between requests
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_result(request);
        void'(pending_q.pop_front());
      end
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        request <= pending_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sita_pkg::out_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", result.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          error_count++;
        end
        if (result.group_key !== want.group_key) begin
          $error("group_key: expected %0h, got %0h", want.group_key, result.group_key);
          error_count++;
        end
        if (result.group_average !== want.group_average) begin
          $error("group_average: expected %0d, got %0d", want.group_average,
                 result.group_average);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with neither a request taken nor a result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic add_insert(input logic [sita_pkg::KEY_W-1:0] k,
                            input logic [sita_pkg::VAL_W-1:0] v);
    sita_pkg::in_t r;
    r.kind = sita_pkg::KIND_INSERT;
    r.record_key = k;
    r.record_value = v;
    pending_q.push_back(r);
    if (gen_fill < sita_pkg::CAPACITY) gen_fill++;
  endtask

  task automatic add_take();
    sita_pkg::in_t r;
    r.kind = sita_pkg::KIND_TAKE;
    r.record_key = {$urandom};
    r.record_value = sita_pkg::VAL_W'($urandom);
    pending_q.push_back(r);
    gen_fill = (gen_fill >= sita_pkg::GROUP_SIZE) ? gen_fill - sita_pkg::GROUP_SIZE : 0;
  endtask

  function automatic logic [sita_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(7))
      0, 1: return sita_pkg::KEY_W'($urandom_range(7));   // crowd of equal keys
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      default: return {$urandom};
    endcase
  endfunction

  function automatic logic [sita_pkg::VAL_W-1:0] rand_value();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
    return sita_pkg::VAL_W'($urandom_range(1023));
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int pct, input bit fill_first);
    int n;
    int len;
    int ins_pct;
    wait_drained();
    idle_pct = pct;
    n = 0;
    if (fill_first) begin
      // run into the full store, then two inserts that must bounce
      while (gen_fill < sita_pkg::CAPACITY) begin
        add_insert(rand_key(), rand_value());
        n++;
      end
      add_insert(rand_key(), rand_value());
      add_insert(rand_key(), rand_value());
      n += 2;
    end
    while (n < PHASE_ITEMS) begin
      case ($urandom_range(9))
        0: begin
          while (gen_fill > 0) begin
            add_take();
            n++;
          end
          add_take();
          n++;
        end
        default: begin
          len = $urandom_range(30, 5);
          ins_pct = ($urandom_range(1) != 0) ? 75 : 45;
          repeat (len) begin
            if ($urandom_range(99) < ins_pct) add_insert(rand_key(), rand_value());
            else add_take();
          end
          n += len;
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty take, short groups of one and two
    add_take();
    add_insert(32'd5, 10'd1);
    add_take();
    add_insert('1, '1);
    add_insert('0, '0);
    add_take();
    // full group with top values, out-of-order inserts
    add_insert(32'd30, '1);
    add_insert(32'd10, '1);
    add_insert(32'd20, '1);
    add_take();
    // equal keys at the tail keep arrival order
    add_insert(32'd7, 10'd1);
    add_insert(32'd7, 10'd2);
    add_insert(32'd7, 10'd3);
    add_insert(32'd7, 10'd1000);
    add_take();
    add_take();
    // equal key in the middle goes in front of the stored one
    add_insert(32'd10, 10'd0);
    add_insert(32'd20, 10'd0);
    add_insert(32'd30, 10'd0);
    add_insert(32'd20, 10'd999);
    add_take();
    add_take();

    random_phase(0, 1'b0);
    random_phase(60, 1'b0);
    random_phase(0, 1'b1);   // receiver cannot stall, so no idling here
    random_phase(32, 1'b0);
    wait_drained();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
